[rtl/ldfw_pkg.sv]
// ----------------------------------------------------------------------------
// ldfw_pkg
// Shared types and constants for the LCD decimal field writer.
// ----------------------------------------------------------------------------
package ldfw_pkg;

    // Field widths
    localparam int VALUE_W       = 32;
    localparam int LINE_W        = 2;
    localparam int COLUMN_W      = 6;
    localparam int DCOUNT_W      = 4;
    localparam int NIBBLE_W      = 4;
    localparam int BYTE_W        = 8;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 8;
    localparam int OUT_TUSER_W   = 2;

    // Decimal conversion
    localparam int MAX_DIGITS    = 10;
    localparam int BCD_DIGITS    = 10;
    localparam int DIGIT_IDX_W   = 4;
    localparam int CONV_CNT_W    = 5;
    localparam logic [CONV_CNT_W-1:0] CONV_LAST = CONV_CNT_W'(VALUE_W - 1);

    // Display codes
    localparam logic [LINE_W-1:0]   LINE_FIRST     = 2'd1;
    localparam logic [BYTE_W-1:0]   LINE_TWO_BASE  = 8'd64;
    localparam logic [BYTE_W-1:0]   SET_ADDR_CMD   = 8'h80;
    localparam logic [NIBBLE_W-1:0] ASCII_DIGIT_HI = 4'h3;
    localparam logic                RS_COMMAND     = 1'b0;
    localparam logic                RS_DATA        = 1'b1;

    // Queue depth
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_CNT_W   = 2;

    // Classified job handed from front to back
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic                has_cmd;
        logic [BYTE_W-1:0]   cmd_byte;
        logic                has_digits;
        logic [DCOUNT_W-1:0] digit_count;
    } job_t;

    // Queue status seen by front, back and checks
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[rtl/ldfw_front.sv]
// ----------------------------------------------------------------------------
// ldfw_front
// Accepts input words and classifies them into jobs for the queue.
// ----------------------------------------------------------------------------
module ldfw_front
(
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ldfw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  ldfw_pkg::queue_status_t          q_status,
    output logic                             q_push,
    output ldfw_pkg::job_t                   q_job
);
    import ldfw_pkg::*;

    logic [VALUE_W-1:0]  value;
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
    logic [DCOUNT_W-1:0] digit_count;
    logic [BYTE_W-1:0]   base;
    logic [BYTE_W-1:0]   addr;

    // Unpack the input word
    assign value       = s_axis_tdata[31:0];
    assign line        = s_axis_tdata[33:32];
    assign column      = s_axis_tdata[39:34];
    assign digit_count = s_axis_tdata[43:40];

    // Build the set-address command byte
    assign base = (line == LINE_FIRST) ? '0 : LINE_TWO_BASE;
    assign addr = base + {{(BYTE_W-COLUMN_W){1'b0}}, column} - 8'd1;

    // Classify the job
    always_comb
    begin
        q_job.value       = value;
        q_job.has_cmd     = (line != '0) && (column != '0);
        q_job.cmd_byte    = SET_ADDR_CMD | addr;
        q_job.has_digits  = (digit_count != '0) &&
                            ({28'd0, digit_count} <= 32'(MAX_DIGITS));
        q_job.digit_count = digit_count;
    end

    // Accept while the queue has room
    assign s_axis_tready = !q_status.full;
    assign q_push        = s_axis_tvalid && !q_status.full;

endmodule

[rtl/ldfw_queue.sv]
// ----------------------------------------------------------------------------
// ldfw_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module ldfw_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ldfw_pkg::job_t          push_job,
    input  logic                    pop,
    output ldfw_pkg::job_t          pop_job,
    output ldfw_pkg::queue_status_t status
);
    import ldfw_pkg::*;

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Hold job payloads
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/ldfw_back.sv]
// ----------------------------------------------------------------------------
// ldfw_back
// Converts a job's value to decimal and emits its nibble sequence.
// ----------------------------------------------------------------------------
module ldfw_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ldfw_pkg::queue_status_t           q_status,
    input  ldfw_pkg::job_t                    q_job,
    output logic                              q_pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ldfw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [ldfw_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    output logic                              m_axis_tlast
);
    import ldfw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CMD_HI,
        ST_CMD_LO,
        ST_DIG_HI,
        ST_DIG_LO
    } state_t;

    state_t                                  state_reg;
    logic [VALUE_W-1:0]                      shift_reg;
    logic [BCD_DIGITS-1:0][NIBBLE_W-1:0]     bcd_reg;
    logic [BCD_DIGITS-1:0][NIBBLE_W-1:0]     bcd_adj;
    logic [CONV_CNT_W-1:0]                   conv_cnt_reg;
    logic [DIGIT_IDX_W-1:0]                  dig_idx_reg;
    logic                                    has_cmd_reg;
    logic                                    has_digits_reg;
    logic [BYTE_W-1:0]                       cmd_byte_reg;
    logic                                    out_valid_reg;
    logic                                    out_rs_reg;
    logic [NIBBLE_W-1:0]                     out_nibble_reg;
    logic                                    out_high_reg;
    logic                                    out_last_reg;
    logic                                    out_free;
    logic                                    emit;

    // Take a job only when idle
    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign emit     = out_free &&
                      (state_reg inside {ST_CMD_HI, ST_CMD_LO, ST_DIG_HI, ST_DIG_LO});

    // Add-three correction on every BCD digit
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    // State and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            out_rs_reg     <= RS_COMMAND;
            out_nibble_reg <= '0;
            out_high_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // Load a new word or drop the one just taken
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        if (q_job.has_digits)
                        begin
                            state_reg <= ST_CONV;
                        end
                        else if (q_job.has_cmd)
                        begin
                            state_reg <= ST_CMD_HI;
                        end
                    end
                end
                ST_CONV:
                begin
                    if (conv_cnt_reg == CONV_LAST)
                    begin
                        state_reg <= has_cmd_reg ? ST_CMD_HI : ST_DIG_HI;
                    end
                end
                ST_CMD_HI:
                begin
                    if (out_free)
                    begin
                        out_rs_reg     <= RS_COMMAND;
                        out_nibble_reg <= cmd_byte_reg[7:4];
                        out_high_reg   <= 1'b1;
                        out_last_reg   <= 1'b0;
                        state_reg      <= ST_CMD_LO;
                    end
                end
                ST_CMD_LO:
                begin
                    if (out_free)
                    begin
                        out_rs_reg     <= RS_COMMAND;
                        out_nibble_reg <= cmd_byte_reg[3:0];
                        out_high_reg   <= 1'b0;
                        out_last_reg   <= !has_digits_reg;
                        state_reg      <= has_digits_reg ? ST_DIG_HI : ST_IDLE;
                    end
                end
                ST_DIG_HI:
                begin
                    if (out_free)
                    begin
                        out_rs_reg     <= RS_DATA;
                        out_nibble_reg <= ASCII_DIGIT_HI;
                        out_high_reg   <= 1'b1;
                        out_last_reg   <= 1'b0;
                        state_reg      <= ST_DIG_LO;
                    end
                end
                ST_DIG_LO:
                begin
                    if (out_free)
                    begin
                        out_rs_reg     <= RS_DATA;
                        out_nibble_reg <= bcd_reg[dig_idx_reg];
                        out_high_reg   <= 1'b0;
                        out_last_reg   <= (dig_idx_reg == '0);
                        state_reg      <= (dig_idx_reg == '0) ? ST_IDLE : ST_DIG_HI;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload and conversion registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                shift_reg      <= q_job.value;
                bcd_reg        <= '0;
                conv_cnt_reg   <= '0;
                has_cmd_reg    <= q_job.has_cmd;
                has_digits_reg <= q_job.has_digits;
                cmd_byte_reg   <= q_job.cmd_byte;
                dig_idx_reg    <= q_job.digit_count - 1'b1;
            end
            ST_CONV:
            begin
                // Shift one binary bit into the BCD digits
                {bcd_reg, shift_reg} <= {bcd_adj, shift_reg} << 1;
                conv_cnt_reg         <= conv_cnt_reg + 1'b1;
            end
            ST_DIG_LO:
            begin
                if (out_free)
                begin
                    dig_idx_reg <= dig_idx_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-NIBBLE_W){1'b0}}, out_nibble_reg};
    assign m_axis_tuser  = {out_high_reg, out_rs_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[rtl/lcd_decimal_field_writer_unit.sv]
// ----------------------------------------------------------------------------
// lcd_decimal_field_writer_unit
// Writes a 32-bit number as decimal digits on a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
// Each input word carries a number, a line, a column and a digit count; the
// unit answers with a run of bus nibbles (high half first), an optional
// set-address command followed by the requested low decimal digits as ASCII,
// and tlast on the final nibble. A word with nothing to show yields no output.
// The front queues up to two classified words so input is taken while the
// back is busy. The back handles one word at a time: it picks the word up,
// runs binary-to-BCD shifting when digits are shown (the conversion loop),
// then emits the nibbles in turn, holding each while the output side stalls.
module lcd_decimal_field_writer_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: value[31:0], line[33:32], column[39:34], digit_count[43:40]
    input  logic [ldfw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: nibble[3:0]
    output logic [ldfw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser: reg_select[0], high_half[1]
    output logic [ldfw_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);
    import ldfw_pkg::*;

    job_t          push_job;
    job_t          pop_job;
    logic          q_push;
    logic          q_pop;
    queue_status_t q_status;

    // Front: accept and classify
    ldfw_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    // Queue between front and back
    ldfw_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    // Back: convert and emit
    ldfw_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_job         (pop_job),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Queue is never full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status is full and empty");

    // A high half never ends a run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tlast)
        else $error("tlast on a high nibble");

    // Digit characters always carry the ASCII digit upper nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1]
            |-> m_axis_tdata[3:0] == ASCII_DIGIT_HI)
        else $error("bad upper nibble on a digit");

endmodule
